// File: sv/tfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfs_pkg
// Shared constants and types of the timestamp table floor search block.
// ----------------------------------------------------------------------------
package tfs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int TIME_W      = 64;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_BASE_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT      = 1'd1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [TIME_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } ram_req_t;

endpackage
`default_nettype wire

// File: sv/tfs_table_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfs_table_ram
// Timestamp table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tfs_table_ram (
    input  wire logic                      clk,
    input  wire tfs_pkg::ram_req_t         req,
    output logic [tfs_pkg::TIME_W-1:0]     rd_data
);

    logic [tfs_pkg::TIME_W-1:0] mem [tfs_pkg::TABLE_DEPTH];
    logic [tfs_pkg::TIME_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: sv/tfs_search_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfs_search_ctrl
// Load and query sequencer: writes table entries, runs the binary search
// one memory probe per cycle and holds the result word.
// ----------------------------------------------------------------------------
module tfs_search_ctrl (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              mode,
    input  wire logic [tfs_pkg::IDX_W-1:0]         entry_index,
    input  wire logic signed [tfs_pkg::TIME_W-1:0] time_value,
    input  wire logic signed [tfs_pkg::TIME_W-1:0] time_base_offset,
    input  wire logic [tfs_pkg::CNT_W-1:0]         entry_count,
    output tfs_pkg::ram_req_t                      ram_req,
    input  wire logic [tfs_pkg::TIME_W-1:0]        rd_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [tfs_pkg::IDX_W-1:0]              floor_index,
    output logic                                   no_table
);

    tfs_pkg::state_t state_reg;
    tfs_pkg::state_t state_next;

    logic [tfs_pkg::CNT_W-1:0]         lo_reg;
    logic [tfs_pkg::CNT_W-1:0]         hi_reg;
    logic [tfs_pkg::CNT_W-1:0]         mid_reg;
    logic signed [tfs_pkg::TIME_W-1:0] key_reg;
    logic signed [tfs_pkg::TIME_W-1:0] floor_time_reg;
    logic                              empty_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [tfs_pkg::IDX_W-1:0]         floor_index_reg;
    logic                              no_table_reg;

    logic                              in_accept;
    logic                              is_query;
    logic                              count_zero;
    logic [tfs_pkg::CNT_W-1:0]         count_sat;
    logic [tfs_pkg::CNT_W-1:0]         start_mid;
    logic                              probe_le;
    logic [tfs_pkg::CNT_W-1:0]         lo_upd;
    logic [tfs_pkg::CNT_W-1:0]         hi_upd;
    logic [tfs_pkg::CNT_W:0]           mid_sum;
    logic [tfs_pkg::CNT_W-1:0]         mid_upd;
    logic                              probe_more;
    logic                              out_free;
    logic [tfs_pkg::IDX_W-1:0]         result_index;

    assign in_stall   = (state_reg != tfs_pkg::S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign is_query   = (mode == tfs_pkg::MODE_QUERY);
    assign count_zero = (entry_count == '0);
    assign count_sat  = (entry_count > tfs_pkg::DEPTH_CNT) ? tfs_pkg::DEPTH_CNT : entry_count;
    assign start_mid  = count_sat >> 1;

    assign probe_le   = ($signed(rd_data) <= key_reg);
    assign lo_upd     = probe_le ? (mid_reg + 1'b1) : lo_reg;
    assign hi_upd     = probe_le ? hi_reg : mid_reg;
    assign mid_sum    = {1'b0, lo_upd} + {1'b0, hi_upd};
    assign mid_upd    = mid_sum[tfs_pkg::CNT_W:1];
    assign probe_more = (lo_upd < hi_upd);

    assign out_free   = !out_valid_reg || !out_stall;

    assign result_index = ((lo_reg != '0) && !(floor_time_reg < time_base_offset))
                          ? tfs_pkg::IDX_W'(lo_reg - 1'b1) : '0;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tfs_pkg::S_IDLE:
            begin
                if (in_accept && is_query)
                begin
                    state_next = count_zero ? tfs_pkg::S_FINISH : tfs_pkg::S_PROBE;
                end
            end
            tfs_pkg::S_PROBE:
            begin
                state_next = probe_more ? tfs_pkg::S_PROBE : tfs_pkg::S_FINISH;
            end
            tfs_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = tfs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tfs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_req        = '0;
        ram_req.waddr  = entry_index;
        ram_req.wdata  = time_value;
        ram_req.raddr  = start_mid[tfs_pkg::IDX_W-1:0];
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            tfs_pkg::S_IDLE:
            begin
                ram_req.we = in_accept && !is_query;
                ram_req.re = in_accept && is_query && !count_zero;
            end
            tfs_pkg::S_PROBE:
            begin
                ram_req.re    = probe_more;
                ram_req.raddr = mid_upd[tfs_pkg::IDX_W-1:0];
            end
            tfs_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                ram_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tfs_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // search registers and result word
    always_ff @(posedge clk)
    begin
        case (state_reg)
            tfs_pkg::S_IDLE:
            begin
                if (in_accept && is_query)
                begin
                    key_reg   <= time_value;
                    lo_reg    <= '0;
                    hi_reg    <= count_sat;
                    mid_reg   <= start_mid;
                    empty_reg <= count_zero;
                end
            end
            tfs_pkg::S_PROBE:
            begin
                lo_reg  <= lo_upd;
                hi_reg  <= hi_upd;
                mid_reg <= mid_upd;
                if (probe_le)
                begin
                    floor_time_reg <= $signed(rd_data);
                end
            end
            tfs_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    floor_index_reg <= result_index;
                    no_table_reg    <= empty_reg;
                end
            end
            default:
            begin
                lo_reg <= '0;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign floor_index = floor_index_reg;
    assign no_table    = no_table_reg;

endmodule
`default_nettype wire

// File: sv/time_table_floor_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// time_table_floor_search
// Floor search over a table of ascending signed 64-bit timestamps.
//
// Input words: mode 0 writes time_value into entry entry_index; mode 1
// searches the first entry_count entries for the last time not above
// time_value. Each query yields one output word (floor_index, no_table);
// loads yield none. A floor below time_base_offset, or no floor at all,
// returns index 0. An entry count of zero returns no_table with index 0.
// Registers are to be written via cfg_we/cfg_index/cfg_data only while idle; the block does not check.
//
// Timing: a load is written from the idle state. A query holds the input stalled
// while it runs: first the table probes, each read through the registered
// table memory, then the step that forms the result; an empty table skips
// the probes. The output word sits in a register; when the receiver stalls it
// holds, and the next query finishes but waits until that word is taken.
// Reset clears the registers and control; the table is undefined until
// written and needs no clearing.
// ----------------------------------------------------------------------------
module time_table_floor_search (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [tfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tfs_pkg::TIME_W-1:0]        cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              mode,
    input  wire logic [tfs_pkg::IDX_W-1:0]         entry_index,
    input  wire logic signed [tfs_pkg::TIME_W-1:0] time_value,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [tfs_pkg::IDX_W-1:0]              floor_index,
    output logic                                   no_table
);

    logic signed [tfs_pkg::TIME_W-1:0] time_base_offset_reg;
    logic [tfs_pkg::CNT_W-1:0]         entry_count_reg;
    tfs_pkg::ram_req_t                 ram_req;
    logic [tfs_pkg::TIME_W-1:0]        rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_base_offset_reg <= '0;
            entry_count_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tfs_pkg::CFG_TIME_BASE_OFFSET:
                begin
                    time_base_offset_reg <= $signed(cfg_data);
                end
                tfs_pkg::CFG_ENTRY_COUNT:
                begin
                    entry_count_reg <= cfg_data[tfs_pkg::CNT_W-1:0];
                end
                default:
                begin
                    entry_count_reg <= entry_count_reg;
                end
            endcase
        end
    end

    tfs_search_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .entry_index      (entry_index),
        .time_value       (time_value),
        .time_base_offset (time_base_offset_reg),
        .entry_count      (entry_count_reg),
        .ram_req          (ram_req),
        .rd_data          (rd_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .floor_index      (floor_index),
        .no_table         (no_table)
    );

    tfs_table_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

endmodule
`default_nettype wire

// File: test/floor_sb_pkg.sv
// ----------------------------------------------------------------------------
// floor_sb_pkg
// Scoreboard for the timestamp table floor search block: keeps a shadow
// copy of the table and the two registers, works out the floor word of
// every accepted query and checks the block's output words in order.
// ----------------------------------------------------------------------------
package floor_sb_pkg;

    import tfs_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] floor_index;
        logic             no_table;
    } floor_word_t;

    class floor_scoreboard;

        logic signed [TIME_W-1:0] stamps [TABLE_DEPTH];
        logic signed [TIME_W-1:0] base_offset;
        logic [CNT_W-1:0]         count;
        floor_word_t              expected_words [$];
        int                       errors;

        function new();
            base_offset = '0;
            count       = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
            if (idx == CFG_TIME_BASE_OFFSET)
                base_offset = data;
            else if (idx == CFG_ENTRY_COUNT)
                count = data[CNT_W-1:0];
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void report(string msg);
            if (errors < 10)
                $display("mismatch: %s", msg);
            errors++;
        endfunction

        // loads update the shadow table, queries predict one floor word
        function void note_input(logic m, logic [IDX_W-1:0] idx,
                                 logic signed [TIME_W-1:0] tv);
            floor_word_t w;
            int unsigned n;
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            if (m == MODE_LOAD)
            begin
                stamps[idx] = tv;
                return;
            end
            w = '0;
            if (count == '0)
            begin
                w.no_table = 1'b1;
            end
            else
            begin
                n  = (count > DEPTH_CNT) ? TABLE_DEPTH : int'(count);
                lo = 0;
                hi = n;
                while (lo < hi)
                begin
                    mid = (lo + hi) / 2;
                    if (stamps[mid] <= tv)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                if (lo > 0 && stamps[lo-1] >= base_offset)
                    w.floor_index = IDX_W'(lo - 1);
            end
            expected_words.push_back(w);
        endfunction

        function void check_result(logic [IDX_W-1:0] fi, logic nt);
            floor_word_t want;
            if (expected_words.size() == 0)
            begin
                report($sformatf("unexpected word floor_index=%0d no_table=%0b", fi, nt));
                return;
            end
            want = expected_words.pop_front();
            if (fi !== want.floor_index || nt !== want.no_table)
                report($sformatf("floor_index exp %0d got %0d, no_table exp %0b got %0b",
                                 want.floor_index, fi, want.no_table, nt));
        endfunction

    endclass

endpackage

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of time_table_floor_search: loads tables of ascending, clustered
// and unsorted timestamps, sweeps the offset and entry count registers
// (absent, small, full and oversized tables) and runs floor queries under
// random sender gaps and receiver stalls, checking every output word.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tfs_pkg::*;
    import floor_sb_pkg::*;

    localparam logic signed [TIME_W-1:0] T_MIN = {1'b1, {(TIME_W-1){1'b0}}};
    localparam logic signed [TIME_W-1:0] T_MAX = {1'b0, {(TIME_W-1){1'b1}}};
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_OFF_CYCLES = 300;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index   = CFG_TIME_BASE_OFFSET;
    logic [TIME_W-1:0]        cfg_data    = '0;
    logic                     in_valid    = 1'b0;
    logic                     in_stall;
    logic                     mode        = MODE_LOAD;
    logic [IDX_W-1:0]         entry_index = '0;
    logic signed [TIME_W-1:0] time_value  = '0;
    logic                     out_valid;
    logic                     out_stall   = 1'b0;
    logic [IDX_W-1:0]         floor_index;
    logic                     no_table;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off       = 0;
    int items_sent     = 0;

    floor_scoreboard sb = new();

    time_table_floor_search u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .entry_index (entry_index),
        .time_value  (time_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .floor_index (floor_index),
        .no_table    (no_table)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : receiver
        logic             took;
        logic [IDX_W-1:0] got_index;
        logic             got_no_table;
        took         = 1'b0;
        got_index    = '0;
        got_no_table = 1'b0;
        forever
        begin
            @(posedge clk);
            if (took)
                sb.check_result(got_index, got_no_table);
            if (hold_off > 0)
            begin
                out_stall <= 1'b1;
                hold_off--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
            @(negedge clk);
            took         = out_valid && !out_stall;
            got_index    = floor_index;
            got_no_table = no_table;
        end
    end

    task automatic send_word(input logic m, input logic [IDX_W-1:0] idx,
                             input logic signed [TIME_W-1:0] tv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        entry_index <= idx;
        time_value  <= tv;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        sb.note_input(m, idx, tv);
        items_sent++;
    endtask

    task automatic load_entry(input logic [IDX_W-1:0] idx, input logic signed [TIME_W-1:0] tv);
        send_word(MODE_LOAD, idx, tv);
    endtask

    task automatic query(input logic signed [TIME_W-1:0] key);
        send_word(MODE_QUERY, '0, key);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic signed [TIME_W-1:0] offset,
                             input logic [CNT_W-1:0] count);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TIME_BASE_OFFSET;
        cfg_data  <= offset;
        @(posedge clk);
        sb.write_reg(CFG_TIME_BASE_OFFSET, offset);
        cfg_index <= CFG_ENTRY_COUNT;
        cfg_data  <= TIME_W'(count);
        @(posedge clk);
        sb.write_reg(CFG_ENTRY_COUNT, TIME_W'(count));
        cfg_we <= 1'b0;
    endtask

    // write entries 0..n-1 in shuffled order: sorted, clustered or unsorted
    task automatic fill_table(input int n);
        longint vals [$];
        int     order [$];
        int     style;
        style = $urandom_range(9);
        for (int i = 0; i < n; i++)
        begin
            order.push_back(i);
            if (style >= 5 && style < 8)
                vals.push_back(i == 0 ? longint'($signed($urandom))
                                      : vals[i-1] + $urandom_range(3));
            else
                vals.push_back(longint'({$urandom, $urandom}));
        end
        if (style < 5)
        begin
            vals.sort();
            for (int i = 1; i < n; i++)
                if ($urandom_range(3) == 0)
                    vals[i] = vals[i-1];
            if ($urandom_range(3) == 0)
                vals[0] = T_MIN;
            if ($urandom_range(3) == 0)
                vals[n-1] = T_MAX;
        end
        order.shuffle();
        foreach (order[i])
            load_entry(IDX_W'(order[i]), vals[order[i]]);
    endtask

    // write ascending times on the leftmost and rightmost search paths of a
    // full-depth table
    task automatic fill_search_paths();
        int     lo;
        int     hi;
        int     mid;
        int     picks [$];
        longint v;
        for (int side = 0; side < 2; side++)
        begin
            lo = 0;
            hi = TABLE_DEPTH;
            while (lo < hi)
            begin
                mid = (lo + hi) / 2;
                if (!(side == 1 && mid == TABLE_DEPTH / 2))
                    picks.push_back(mid);
                if (side == 0)
                    hi = mid;
                else
                    lo = mid + 1;
            end
        end
        picks.shuffle();
        foreach (picks[i])
        begin
            v = longint'(picks[i]) * 4096 - 1_000_000;
            load_entry(IDX_W'(picks[i]), v);
        end
    endtask

    // queries near table entries and extremes, with stray loads mixed in
    task automatic run_queries(input int n, input int nq);
        int                       at;
        logic signed [TIME_W-1:0] key;
        for (int q = 0; q < nq; q++)
        begin
            at = $urandom_range(n - 1);
            case ($urandom_range(9))
                0:       key = T_MIN;
                1:       key = T_MAX;
                2, 3:    key = sb.stamps[at];
                4:       key = sb.stamps[at] - 1;
                5:       key = sb.stamps[at] + 1;
                default: key = {$urandom, $urandom};
            endcase
            if ($urandom_range(7) == 0)
            begin
                if (q % 2 == 1)
                    load_entry(IDX_W'(at), {$urandom, $urandom});
                else
                    load_entry(IDX_W'($urandom_range(TABLE_DEPTH - 1)), {$urandom, $urandom});
            end
            query(key);
        end
    endtask

    initial
    begin : stimulus
        int                       phase;
        int                       n;
        int                       r;
        logic signed [TIME_W-1:0] offset;
        phase  = 0;
        offset = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // absent table straight after reset and after an explicit zero count
        query(T_MAX);
        configure(T_MIN, '0);
        query(T_MIN);

        load_entry(IDX_W'(0), T_MIN);
        load_entry(IDX_W'(1), TIME_W'(-5));
        load_entry(IDX_W'(2), TIME_W'(-5));
        load_entry(IDX_W'(3), TIME_W'(100));
        configure(T_MIN, CNT_W'(4));
        query(T_MIN);
        query(TIME_W'(-6));
        query(TIME_W'(-5));
        query(TIME_W'(99));
        query(T_MAX);

        // floor below offset
        configure('0, CNT_W'(4));
        query(T_MAX);
        query(TIME_W'(-5));

        // no floor at all
        load_entry(IDX_W'(0), TIME_W'(-10));
        configure(T_MIN, CNT_W'(4));
        query(TIME_W'(-11));
        query(T_MIN);

        // offset at the top of the range
        load_entry(IDX_W'(3), T_MAX);
        configure(T_MAX, CNT_W'(4));
        query(T_MAX);
        query(TIME_W'(-5));

        while (items_sent < 620)
        begin
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            r = $urandom_range(99);
            if (r < 60)
                n = $urandom_range(1, 8);
            else if (r < 90)
                n = $urandom_range(9, 40);
            else
                n = $urandom_range(41, 160);
            fill_table(n);
            case ($urandom_range(5))
                0:       offset = T_MIN;
                1:       offset = T_MAX;
                2:       offset = '0;
                3, 4:    offset = sb.stamps[$urandom_range(n - 1)];
                default: offset = {$urandom, $urandom};
            endcase
            configure(offset, ($urandom_range(9) == 0) ? '0 : CNT_W'(n));
            if (phase % 7 == 2)
                hold_off = HOLD_OFF_CYCLES;
            run_queries(n, $urandom_range(8, 30));
            phase++;
        end

        // full depth, then a count beyond the table depth
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        fill_search_paths();
        configure(T_MIN, DEPTH_CNT);
        query(T_MIN);
        query(T_MAX);
        query(sb.stamps[0]);
        query(sb.stamps[TABLE_DEPTH - 1]);
        query(sb.stamps[TABLE_DEPTH - 1] - 1);
        configure(sb.stamps[TABLE_DEPTH - 1], '1);
        query(T_MAX);
        query(sb.stamps[TABLE_DEPTH - 1] - 1);
        query(T_MIN);

        settle();
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
sv/tfs_pkg.sv
sv/tfs_table_ram.sv
sv/tfs_search_ctrl.sv
sv/time_table_floor_search.sv
test/floor_sb_pkg.sv
test/tb_top.sv
